/* rtl/core/fwth_pkg.sv */
// ----------------------------------------------------------------------------
// fwth_pkg
// Shared types and constants for the FNV-1a word template hash unit.
// ----------------------------------------------------------------------------
package fwth_pkg;

    localparam int HASH_W     = 64;
    localparam int CAT_W      = 32;
    localparam int LEVEL_W    = 3;
    localparam int CNT_W      = 4;
    localparam int BYTE_IDX_W = 3;
    localparam int S_DATA_W   = 104;
    localparam int M_DATA_W   = 128;

    // Offset basis and prime: prime = 2^40 + 0x1B3
    localparam logic [HASH_W-1:0] FNV_BASIS      = 64'hCBF29CE484222325;
    localparam logic [8:0]        FNV_PRIME_LO   = 9'h1B3;
    localparam int                FNV_PRIME_SHFT = 40;

    localparam logic [CNT_W-1:0] FULL_BYTES = 4'd8;
    localparam logic [CNT_W-1:0] WORD_BYTES = 4'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_BYTE,
        ST_LEVEL,
        ST_CAT,
        ST_FIN
    } state_t;

    typedef enum logic [2:0] {
        OP_WORD64,
        OP_WORD32,
        OP_BYTE,
        OP_LEVEL,
        OP_CAT
    } opnd_sel_t;

    typedef struct packed {
        logic                  ready;
        logic                  fold_en;
        opnd_sel_t             opnd_sel;
        logic [BYTE_IDX_W-1:0] byte_idx;
        logic                  save_str;
        logic                  load_out;
        logic                  clear_hash;
    } ctrl_t;

endpackage

/* rtl/core/fwth_fold_unit.sv */
// ----------------------------------------------------------------------------
// fwth_fold_unit
// Shared fold step: XOR an operand into the hash, multiply by the FNV prime.
// ----------------------------------------------------------------------------
module fwth_fold_unit (
    input  logic [fwth_pkg::HASH_W-1:0] hash_in,
    input  logic [fwth_pkg::HASH_W-1:0] opnd,
    output logic [fwth_pkg::HASH_W-1:0] hash_out
);
    import fwth_pkg::*;

    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] lo_prod;
    logic [HASH_W-1:0] hi_part;

    // Split the prime into a shift term and a narrow constant product
    assign mixed    = hash_in ^ opnd;
    assign lo_prod  = mixed * {{(HASH_W-9){1'b0}}, FNV_PRIME_LO};
    assign hi_part  = mixed << FNV_PRIME_SHFT;
    assign hash_out = hi_part + lo_prod;

endmodule

/* rtl/core/fwth_ctrl.sv */
// ----------------------------------------------------------------------------
// fwth_ctrl
// Sequencer that steps the shared fold unit through one chunk and the tail.
// ----------------------------------------------------------------------------
module fwth_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  logic [fwth_pkg::CNT_W-1:0] nbytes,
    input  logic                       is_last,
    input  logic                       out_free,
    output fwth_pkg::ctrl_t            ctrl
);
    import fwth_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    // State and byte position registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // Next state and fold unit control
    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        ctrl            = '0;
        ctrl.opnd_sel   = OP_WORD64;
        ctrl.byte_idx   = pos_reg[BYTE_IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                ctrl.ready = 1'b1;
                if (in_accept) begin
                    state_next = ST_CHUNK;
                end
            end
            ST_CHUNK: begin
                // fold a full word, or the low 32-bit word of a tail
                if (nbytes >= FULL_BYTES) begin
                    ctrl.fold_en  = 1'b1;
                    ctrl.opnd_sel = OP_WORD64;
                    pos_next      = FULL_BYTES;
                end else if (nbytes >= WORD_BYTES) begin
                    ctrl.fold_en  = 1'b1;
                    ctrl.opnd_sel = OP_WORD32;
                    pos_next      = WORD_BYTES;
                end else begin
                    pos_next      = '0;
                end
                state_next = ST_BYTE;
            end
            ST_BYTE: begin
                // fold remaining bytes one at a time
                if (pos_reg < nbytes) begin
                    ctrl.fold_en  = 1'b1;
                    ctrl.opnd_sel = OP_BYTE;
                    pos_next      = pos_reg + 1'b1;
                end else if (is_last) begin
                    state_next = ST_LEVEL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_LEVEL: begin
                ctrl.save_str = 1'b1;
                ctrl.fold_en  = 1'b1;
                ctrl.opnd_sel = OP_LEVEL;
                state_next    = ST_CAT;
            end
            ST_CAT: begin
                ctrl.fold_en  = 1'b1;
                ctrl.opnd_sel = OP_CAT;
                state_next    = ST_FIN;
            end
            ST_FIN: begin
                // hand off once the output register is free
                if (out_free) begin
                    ctrl.load_out   = 1'b1;
                    ctrl.clear_hash = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/fnv1a_word_template_hash_unit.sv */
// ----------------------------------------------------------------------------
// fnv1a_word_template_hash_unit
// 64-bit FNV-1a style string and template hash over 64-bit chunks.
// ----------------------------------------------------------------------------
// Accepts a string as little-endian chunks of up to eight bytes and keeps a
// running 64-bit hash. One shared XOR-and-multiply fold unit does every step,
// one step per cycle, under a small sequencer; the input is not ready while a
// chunk is worked on. A full chunk is folded as one 64-bit word. A short chunk
// folds its low 32-bit word if it holds four bytes or more, then each single
// byte past that word (0 to 3, or up to 3 when fewer than four bytes). A last
// chunk then adds the level and category folds and the hand-off to the output
// register, which waits while that register stays stalled with an earlier
// result. The result sits in an output register, so the next string can start
// while it waits to be taken.
// ----------------------------------------------------------------------------
module fnv1a_word_template_hash_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // chunk_data[63:0], chunk_bytes[67:64], log_severity[70:68],
    // category_index[102:71], zero pad [103]
    input  logic [fwth_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // string_hash[63:0], template_hash[127:64]
    output logic [fwth_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready
);
    import fwth_pkg::*;

    ctrl_t             ctrl;
    logic              in_accept;
    logic              out_free;
    logic [CNT_W-1:0]  raw_bytes;

    logic [HASH_W-1:0]  data_reg;
    logic [CNT_W-1:0]   nbytes_reg;
    logic               last_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [CAT_W-1:0]   cat_reg;

    logic [HASH_W-1:0] work_reg, work_next;
    logic [HASH_W-1:0] str_reg;
    logic [HASH_W-1:0] out_str_reg;
    logic [HASH_W-1:0] out_tmpl_reg;
    logic              m_valid_reg, m_valid_next;

    logic [HASH_W-1:0] opnd;
    logic [HASH_W-1:0] fold_out;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = ctrl.ready;
    assign raw_bytes = s_tdata[67:64];

    // Capture the chunk, saturating the byte count at eight
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            data_reg   <= s_tdata[63:0];
            nbytes_reg <= (raw_bytes > FULL_BYTES) ? FULL_BYTES : raw_bytes;
            last_reg   <= s_tlast;
            level_reg  <= s_tdata[70:68];
            cat_reg    <= s_tdata[102:71];
        end
    end

    fwth_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .nbytes    (nbytes_reg),
        .is_last   (last_reg),
        .out_free  (out_free),
        .ctrl      (ctrl)
    );

    // Select the operand for the shared fold unit
    always_comb begin
        case (ctrl.opnd_sel)
            OP_WORD64: opnd = data_reg;
            OP_WORD32: opnd = {32'd0, data_reg[31:0]};
            OP_BYTE:   opnd = {56'd0, data_reg[{ctrl.byte_idx, 3'b000} +: 8]};
            OP_LEVEL:  opnd = {{(HASH_W-LEVEL_W){1'b0}}, level_reg};
            OP_CAT:    opnd = {{(HASH_W-CAT_W){1'b0}}, cat_reg};
            default:   opnd = '0;
        endcase
    end

    fwth_fold_unit u_fold (
        .hash_in  (work_reg),
        .opnd     (opnd),
        .hash_out (fold_out)
    );

    // Advance the running hash; restart from the basis after each string
    always_comb begin
        work_next = work_reg;
        if (ctrl.clear_hash) begin
            work_next = FNV_BASIS;
        end else if (ctrl.fold_en) begin
            work_next = fold_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_reg <= FNV_BASIS;
        end else begin
            work_reg <= work_next;
        end
    end

    // Hold the string hash before level and category go in
    always_ff @(posedge aclk) begin
        if (ctrl.save_str) begin
            str_reg <= work_reg;
        end
    end

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (ctrl.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            out_str_reg  <= str_reg;
            out_tmpl_reg <= work_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_tmpl_reg, out_str_reg};

endmodule

/* rtl/core/fwth_checker.sv */
// ----------------------------------------------------------------------------
// fwth_checker
// Port-level checks for the FNV-1a word template hash unit.
// ----------------------------------------------------------------------------
module fwth_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic [fwth_pkg::S_DATA_W-1:0] s_tdata,
    input logic                          s_tlast,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [fwth_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready
);
    import fwth_pkg::*;

    // The unit is busy right after taking a chunk
    a_busy_after_transfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after a transfer");

    // A result appears only at the end of busy work
    a_result_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tready))
        else $error("result raised while the input side was idle");

    // No result follows directly from a chunk transfer
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result raised one cycle after a chunk transfer");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or dropped");

endmodule

bind fnv1a_word_template_hash_unit fwth_checker u_fwth_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the FNV-1a word template hash unit.
// ----------------------------------------------------------------------------
// Streams strings into the unit as 64-bit chunks over the input channel and
// keeps its own model of the running hash. Each closing chunk queues an
// expected pair of string hash and template hash. Every result transfer is
// checked field by field against the oldest queued pair. A directed pass
// covers empty strings, every byte count, stray short chunks, data bits past
// the count and extreme level and category values. Random strings then run
// under three traffic patterns: a gappy source with a stalling sink, the
// reverse, and full rate on both sides.
// ----------------------------------------------------------------------------
module testbench;

    import fwth_pkg::*;

    localparam logic [HASH_W-1:0] PRIME64     = 64'h0000_0100_0000_01B3;
    localparam int                CYCLE_LIMIT = 400000;
    localparam int                DRAIN_WAIT  = 32;

    typedef struct packed {
        logic [HASH_W-1:0] string_hash;
        logic [HASH_W-1:0] template_hash;
    } hash_pair_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tvalid;
    logic                m_tready = 1'b0;

    // Model state and expected results
    logic [HASH_W-1:0] string_state;
    hash_pair_t        pending_hashes[$];
    int                error_count   = 0;
    int                cycle_count   = 0;
    int                src_idle_pct  = 0;
    int                sink_stall_pct = 0;

    fnv1a_word_template_hash_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    // 100 MHz-style clock, period 10
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Bound the run length
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Toggle sink readiness per the current stall rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // One XOR-and-multiply step
    function automatic logic [HASH_W-1:0] mix_in(input logic [HASH_W-1:0] h,
                                                 input logic [HASH_W-1:0] v);
        return (h ^ v) * PRIME64;
    endfunction

    // Fold one accepted chunk into the model; queue a result on a closing chunk
    task automatic predict_chunk_hash(input logic [63:0] data, input logic [3:0] nbytes,
                                      input logic last, input logic [2:0] lvl,
                                      input logic [31:0] cat);
        int         count;
        int         pos;
        hash_pair_t pair;
        count = (nbytes > FULL_BYTES) ? 8 : int'(nbytes);
        pos = 0;
        if (count == 8) begin
            string_state = mix_in(string_state, data);
            pos = 8;
        end else if (count >= 4) begin
            string_state = mix_in(string_state, {32'd0, data[31:0]});
            pos = 4;
        end
        while (pos < count) begin
            string_state = mix_in(string_state, {56'd0, data[8*pos +: 8]});
            pos++;
        end
        if (last) begin
            pair.string_hash   = string_state;
            pair.template_hash = mix_in(mix_in(string_state, {61'd0, lvl}), {32'd0, cat});
            pending_hashes.push_back(pair);
            string_state = FNV_BASIS;
        end
    endtask

    // Drive one chunk, hold it until the transfer, then update the model
    task automatic send_chunk(input logic [63:0] data, input logic [3:0] nbytes,
                              input logic last, input logic [2:0] lvl,
                              input logic [31:0] cat);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {1'b0, cat, lvl, nbytes, data};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_chunk_hash(data, nbytes, last, lvl, cat);
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Mostly a legal count, now and then an oversize one that saturates
    function automatic logic [3:0] pick_count(input int lo, input int hi);
        logic [3:0] n;
        if ($urandom_range(99) < 10) n = 4'($urandom_range(15, 9));
        else n = 4'($urandom_range(hi, lo));
        return n;
    endfunction

    // Compare every result transfer with the oldest expectation
    always @(posedge aclk) begin : check_results
        hash_pair_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_hashes.size() == 0) begin
                $display("%0t: result expected none, got %h", $time, m_tdata);
                error_count++;
            end else begin
                want = pending_hashes.pop_front();
                if (m_tdata[63:0] !== want.string_hash) begin
                    $display("%0t: string_hash expected %h, got %h",
                             $time, want.string_hash, m_tdata[63:0]);
                    error_count++;
                end
                if (m_tdata[127:64] !== want.template_hash) begin
                    $display("%0t: template_hash expected %h, got %h",
                             $time, want.template_hash, m_tdata[127:64]);
                    error_count++;
                end
            end
        end
    end

    // Corner cases: empty string, every byte count, stray short chunks
    task automatic test_directed_corners();
        int n;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // Empty string hashes to the offset basis
        send_chunk(64'd0, 4'd0, 1'b1, 3'd0, 32'd0);
        // Full chunks with all ones then all zeros, extreme level and category
        send_chunk({64{1'b1}}, FULL_BYTES, 1'b0, 3'd0, 32'd0);
        send_chunk(64'd0, FULL_BYTES, 1'b1, 3'd7, 32'hFFFF_FFFF);
        // Every count as a closing chunk; ones above the count must be ignored
        for (n = 1; n < 16; n++) begin
            send_chunk({64{1'b1}}, n[3:0], 1'b1, n[2:0], {n[3:0], 28'h5A5_A5A5});
        end
        // Short chunk in mid-string, then a five-byte tail
        send_chunk(64'h0123_4567_89AB_CDEF, 4'd3, 1'b0, 3'd7, 32'hFFFF_FFFF);
        send_chunk(64'hFEDC_BA98_7654_3210, 4'd5, 1'b1, 3'd3, 32'h8000_0001);
        // Level and category on a body chunk are ignored
        send_chunk(64'hDEAD_BEEF_CAFE_F00D, FULL_BYTES, 1'b0, 3'd5, 32'h1234_5678);
        send_chunk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 3'd1, 32'h0000_0001);
    endtask

    // Random strings with random content; one pick in ten is a stray short chunk
    task automatic test_random_strings(input int n_items, input int src_idle,
                                       input int sink_stall);
        int sent;
        int body;
        sent           = 0;
        src_idle_pct   = src_idle;
        sink_stall_pct = sink_stall;
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                send_chunk(random_word(), pick_count(0, 7), 1'b0, 3'($urandom), $urandom);
                sent++;
            end else begin
                body = ($urandom_range(99) < 10) ? $urandom_range(12) : $urandom_range(3);
                repeat (body) begin
                    send_chunk(random_word(), pick_count(8, 8), 1'b0, 3'($urandom),
                               $urandom);
                    sent++;
                end
                send_chunk(random_word(), pick_count(0, 8), 1'b1, 3'($urandom), $urandom);
                sent++;
            end
        end
    endtask

    initial begin
        string_state = FNV_BASIS;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_corners();
        test_random_strings(150, 31, 54);
        test_random_strings(150, 54, 31);
        test_random_strings(150, 0, 0);

        // Drain outstanding results, then let the pipeline settle
        s_tvalid <= 1'b0;
        sink_stall_pct = 0;
        while (pending_hashes.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/fwth_pkg.sv
rtl/core/fwth_fold_unit.sv
rtl/core/fwth_ctrl.sv
rtl/core/fnv1a_word_template_hash_unit.sv
rtl/core/fwth_checker.sv
dv/testbench.sv
